// ----- src/atst_pkg.sv -----
// shared types, codes and constants for the actuator test session timer
// no dependencies; imported by every module of the block
`default_nettype none

package atst_pkg;

	localparam int unsigned ACTUATOR_COUNT = 8;
	localparam logic [23:0] TIMEOUT_CAP_MS = 24'd30000;

	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;

	localparam logic [7:0] KIND_PCT = 8'd0;
	localparam logic [7:0] KIND_PWM = 8'd1;

	localparam logic [2:0] REJ_NONE     = 3'd0;
	localparam logic [2:0] REJ_ACTUATOR = 3'd1;
	localparam logic [2:0] REJ_TIMEOUT  = 3'd2;
	localparam logic [2:0] REJ_VALUE    = 3'd3;
	localparam logic [2:0] REJ_KIND     = 3'd4;

	localparam logic [2:0] HALT_NONE      = 3'd0;
	localparam logic [2:0] HALT_TIMEOUT   = 3'd1;
	localparam logic [2:0] HALT_UNSAFE    = 3'd2;
	localparam logic [2:0] HALT_REPLACED  = 3'd3;
	localparam logic [2:0] HALT_CANCELLED = 3'd4;

	// percent limit in q12.8 and pwm window in signed q14.8
	localparam logic [19:0] PCT_MAX = 20'd25600;
	localparam logic signed [21:0] PWM_LO = 22'sd204800;
	localparam logic signed [21:0] PWM_HI = 22'sd563200;

	// x / 25 as (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 2^19
	localparam int unsigned PCT_SHIFT = 28;
	localparam logic [23:0] PCT_RECIP = 24'd10737419;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [31:0]        now_ms;
		logic [7:0]         target_actuator;
		logic [7:0]         throttle_kind;
		logic signed [19:0] throttle_amount;
		logic [23:0]        duration_seconds;
		logic               safe_flag;
	} item_t;

	typedef struct packed {
		logic [2:0]         reject;
		logic [23:0]        limit_ms;
		logic               is_pwm;
		logic signed [15:0] demand;
		logic [11:0]        pulse;
	} start_chk_t;

	typedef struct packed {
		logic [2:0]         halt_reason;
		logic [11:0]        drive_pulse_us;
		logic signed [15:0] drive_demand;
		logic               drive_is_pwm;
		logic [4:0]         drive_actuator;
		logic               test_active;
		logic [2:0]         reject_code;
		logic               accepted;
	} result_t;

endpackage

`default_nettype wire

// ----- src/atst_start_check.sv -----
// start request validation: actuator range, timeout conversion, throttle kind and range checks, throttle scaling
// depends on atst_pkg
`default_nettype none

module atst_start_check (
	input  atst_pkg::item_t      item,
	output atst_pkg::start_chk_t chk
);
	import atst_pkg::*;

	logic [33:0]        dur_x;
	logic [17:0]        dur_fl;
	logic [23:0]        tmo;
	logic               amt_neg;
	logic [19:0]        mag;
	logic [18:0]        pct_num;
	logic [42:0]        pct_prod;
	logic [14:0]        pct_q;
	logic signed [21:0] amt_w;
	logic signed [21:0] amt_rnd;

	// seconds q8.16 times 1000 gives ms q.16
	assign dur_x  = ({item.duration_seconds, 10'b0})
		- 34'({item.duration_seconds, 4'b0})
		- 34'({item.duration_seconds, 3'b0});
	assign dur_fl = dur_x[33:16];

	always_comb begin
		if (24'(dur_fl) >= TIMEOUT_CAP_MS) begin
			tmo = TIMEOUT_CAP_MS;
		end else if (dur_fl == 18'd0) begin
			tmo = 24'd1;
		end else begin
			tmo = 24'(dur_fl) + 24'(dur_x[15]);
		end
	end

	assign amt_neg  = item.throttle_amount[19];
	assign mag      = amt_neg ? (~item.throttle_amount + 20'd1) : item.throttle_amount;
	assign pct_num  = {mag[14:0], 4'b0} + 19'd12;
	assign pct_prod = 43'(pct_num) * 43'(PCT_RECIP);
	assign pct_q    = pct_prod[PCT_SHIFT +: 15];

	assign amt_w   = 22'(item.throttle_amount);
	assign amt_rnd = amt_w + 22'sd128;

	always_comb begin
		chk.reject   = REJ_NONE;
		chk.limit_ms = tmo;
		chk.is_pwm   = 1'b0;
		chk.demand   = '0;
		chk.pulse    = '0;
		if (32'(item.target_actuator) >= ACTUATOR_COUNT) begin
			chk.reject = REJ_ACTUATOR;
		end else if (item.duration_seconds == 24'd0) begin
			chk.reject = REJ_TIMEOUT;
		end else if (item.throttle_kind == KIND_PCT) begin
			if (mag > PCT_MAX) begin
				chk.reject = REJ_VALUE;
			end else begin
				chk.demand = amt_neg ? -16'(pct_q) : 16'(pct_q);
			end
		end else if (item.throttle_kind == KIND_PWM) begin
			if (amt_w < PWM_LO || amt_w > PWM_HI) begin
				chk.reject = REJ_VALUE;
			end else begin
				chk.is_pwm = 1'b1;
				chk.pulse  = amt_rnd[19:8];
			end
		end else begin
			chk.reject = REJ_KIND;
		end
	end

endmodule

`default_nettype wire

// ----- src/atst_session.sv -----
// session state, command decode and result register
// depends on atst_pkg and atst_start_check
`default_nettype none

module atst_session (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  atst_pkg::item_t   item,
	output atst_pkg::result_t res
);
	import atst_pkg::*;

	start_chk_t         chk;
	logic               running_q;
	logic [31:0]        began_at_q;
	logic [23:0]        limit_q;
	logic [4:0]         held_act_q;
	logic               held_pwm_q;
	logic signed [15:0] held_demand_q;
	logic [11:0]        held_pulse_q;
	logic [2:0]         halt_q;
	result_t            res_q;

	logic               n_running;
	logic [31:0]        n_began;
	logic [23:0]        n_limit;
	logic [4:0]         n_act;
	logic               n_pwm;
	logic signed [15:0] n_demand;
	logic [11:0]        n_pulse;
	logic [2:0]         n_halt;
	logic               acc;
	logic [2:0]         rej;
	logic               do_halt;
	logic [2:0]         why;
	logic [31:0]        elapsed;

	atst_start_check u_chk (
		.item (item),
		.chk  (chk)
	);

	assign elapsed = item.now_ms - began_at_q;

	always_comb begin
		n_running = running_q;
		n_began   = began_at_q;
		n_limit   = limit_q;
		n_act     = held_act_q;
		n_pwm     = held_pwm_q;
		n_demand  = held_demand_q;
		n_pulse   = held_pulse_q;
		n_halt    = halt_q;
		acc       = 1'b0;
		rej       = REJ_NONE;
		do_halt   = 1'b0;
		why       = HALT_NONE;
		unique case (item.cmd)
			CMD_START: begin
				rej = chk.reject;
				if (chk.reject == REJ_NONE) begin
					acc       = 1'b1;
					n_halt    = running_q ? HALT_REPLACED : HALT_NONE;
					n_running = 1'b1;
					n_began   = item.now_ms;
					n_limit   = chk.limit_ms;
					n_act     = item.target_actuator[4:0];
					n_pwm     = chk.is_pwm;
					n_demand  = chk.demand;
					n_pulse   = chk.pulse;
				end
			end
			CMD_UPDATE: begin
				if (running_q) begin
					if (!item.safe_flag) begin
						do_halt = 1'b1;
						why     = HALT_UNSAFE;
					end else if (elapsed >= 32'(limit_q)) begin
						do_halt = 1'b1;
						why     = HALT_TIMEOUT;
					end
				end
			end
			CMD_CANCEL: begin
				do_halt = 1'b1;
				why     = HALT_CANCELLED;
			end
			default: begin
			end
		endcase
		if (do_halt) begin
			n_running = 1'b0;
			n_act     = '0;
			n_pwm     = 1'b0;
			n_demand  = '0;
			n_pulse   = '0;
			n_halt    = why;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			began_at_q    <= '0;
			limit_q       <= '0;
			held_act_q    <= '0;
			held_pwm_q    <= 1'b0;
			held_demand_q <= '0;
			held_pulse_q  <= '0;
			halt_q        <= HALT_NONE;
		end else if (adv) begin
			running_q     <= n_running;
			began_at_q    <= n_began;
			limit_q       <= n_limit;
			held_act_q    <= n_act;
			held_pwm_q    <= n_pwm;
			held_demand_q <= n_demand;
			held_pulse_q  <= n_pulse;
			halt_q        <= n_halt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.accepted       <= acc;
			res_q.reject_code    <= rej;
			res_q.test_active    <= n_running;
			res_q.drive_actuator <= n_act;
			res_q.drive_is_pwm   <= n_pwm;
			res_q.drive_demand   <= n_demand;
			res_q.drive_pulse_us <= n_pulse;
			res_q.halt_reason    <= n_halt;
		end
	end

	assign res = res_q;

	// idle session holds no command
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (held_act_q == 5'd0 && !held_pwm_q
			&& held_demand_q == 16'sd0 && held_pulse_q == 12'd0))
		else $error("idle session holds a command");

	// only one of demand and pulse is in use
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		held_pwm_q ? (held_demand_q == 16'sd0) : (held_pulse_q == 12'd0))
		else $error("demand and pulse both set");

	// an accepted start leaves a running test
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item.cmd == CMD_START && chk.reject == REJ_NONE) |=> running_q)
		else $error("accepted start did not run");

	// a halting request always stops the test
	a_halt_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && do_halt) |=> (!running_q && halt_q != HALT_NONE))
		else $error("halt did not stop the test");

	// an accepted result carries no reject code and shows a running test
	a_acc_res: assert property (@(posedge clk) disable iff (!arst_n)
		($past(adv) && res_q.accepted) |->
			(res_q.reject_code == REJ_NONE && res_q.test_active))
		else $error("accepted result inconsistent");

endmodule

`default_nettype wire

// ----- src/actuator_test_session_timer.sv -----
// top level of the actuator test session timer: input register and stream handshake
// depends on atst_pkg and atst_session
//
// one stream of requests in, one stream of results out; every request gives
// exactly one result showing the session state after that request.
// s_axis_tuser carries the command (start, time update, cancel); s_axis_tdata
// carries time, actuator, throttle kind and amount, duration and safe flag.
// a request taken from s_axis sits in the input register until it can
// advance, then is decoded and applied to the session state, and its
// result is registered with it and shows on m_axis. one request per
// cycle is sustained while m_axis_tready is high, since the session
// state is updated in the same cycle as the result. when the receiver
// stalls, the pending result holds on m_axis, one more request waits in
// the input register and s_axis_tready then drops until the result is
// taken. reset clears the session (no test running, halt reason none)
// and empties both registers.
`default_nettype none

module actuator_test_session_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// now_ms, target_actuator, throttle_kind, throttle_amount, duration_seconds,
	// safe_flag, zero fill
	input  logic [95:0] s_axis_tdata,
	// cmd
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// accepted, reject_code, test_active, drive_actuator, drive_is_pwm,
	// drive_demand, drive_pulse_us, halt_reason, zero fill
	output logic [47:0] m_axis_tdata
);
	import atst_pkg::*;

	logic    in_acc;
	logic    adv;
	logic    v_s1;
	logic    out_v_q;
	item_t   item_s1;
	result_t res;

	assign adv           = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.cmd              <= s_axis_tuser;
			item_s1.now_ms           <= s_axis_tdata[31:0];
			item_s1.target_actuator  <= s_axis_tdata[39:32];
			item_s1.throttle_kind    <= s_axis_tdata[47:40];
			item_s1.throttle_amount  <= s_axis_tdata[67:48];
			item_s1.duration_seconds <= s_axis_tdata[91:68];
			item_s1.safe_flag        <= s_axis_tdata[92];
		end
	end

	atst_session u_session (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (res)
	);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {6'b0, res.halt_reason, res.drive_pulse_us, res.drive_demand,
		res.drive_is_pwm, res.drive_actuator, res.test_active, res.reject_code,
		res.accepted};

endmodule

`default_nettype wire
